/* sv/local_alignment_score_row_macros.svh */
// Assertion macros shared by the alignment row engine.
// Each macro takes a label, a trigger condition and a consequence.
// Both macros sample on clk and are disabled during rst.
`ifndef LOCAL_ALIGNMENT_SCORE_ROW_MACROS_SVH
`define LOCAL_ALIGNMENT_SCORE_ROW_MACROS_SVH

`ifndef SYNTHESIS

// The consequence must hold in the same cycle as the trigger.
`define LAS_ASSERT_IMPLY(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequence must hold in the cycle after the trigger.
`define LAS_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define LAS_ASSERT_IMPLY(label, trig, cons)
`define LAS_ASSERT_NEXT(label, trig, cons)

`endif

`endif

/* sv/las_pkg.sv */
`default_nettype none

package las_pkg;

  localparam int MAX_COLUMNS = 32;
  localparam int MAX_ROWS    = 4096;
  localparam int SYMBOL_BITS = 8;

  localparam int COL_IDX_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ACT_W       = 7;
  localparam int ROW_W       = 13;
  localparam int SCORE_W     = 10;
  localparam int CALC_W      = SCORE_W + 2;
  localparam int SCORE_MAX   = (1 << SCORE_W) - 1;
  localparam int CFG_W       = 7;
  localparam int CFG_INDEX_W = 2;

  localparam logic [ACT_W-1:0] ACTIVE_RESET   = 7'd8;
  localparam logic [3:0]       MATCH_RESET    = 4'd1;
  localparam logic [4:0]       MISMATCH_RESET = 5'h1F;
  localparam logic [4:0]       GAP_RESET      = 5'h1F;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_ROW  = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ACTIVE_COLUMNS = 2'd0,
    CFG_MATCH          = 2'd1,
    CFG_MISMATCH       = 2'd2,
    CFG_GAP            = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_LEFT = 2'd2,
    DIR_DIAG = 2'd3
  } dir_t;

  typedef enum logic {
    ST_IDLE,
    ST_ROW
  } state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] symbol;
    logic [5:0] load_column;
    logic       new_alignment;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  column;
    logic [9:0]  score;
    logic [1:0]  direction;
    logic [9:0]  best_score;
    logic [12:0] best_row;
    logic [6:0]  best_col;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [3:0] match_score;
    logic [4:0] mismatch_score;
    logic [4:0] gap_score;
  } cell_cfg_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    dir_t               dir;
  } cell_res_t;

endpackage

`default_nettype wire

/* sv/local_alignment_score_row.sv */
// Smith-Waterman row engine with a linear gap penalty.
// The input channel (in_valid/in_ready/in_data) takes two kinds of word.
// A load word writes one reference symbol into the column store and gives
// no result. A row word carries one query symbol and gives one result word
// per active column, column 1 first, with the cell score, the traceback
// move, the running best score with its row and column, and a last flag on
// the final column. new_alignment on a row word clears the previous row,
// the row count and the best values before the row is scored.
// A row word is taken only while the engine is idle. Each column is read
// into registered data, scored by the cell stage and registered at the
// output; one result follows each cycle unless the receiver stalls, and the
// next word can be taken on the cycle after the final column is scored. Load
// words are taken back to back while idle. A stalled receiver holds the
// output register, which in turn freezes the memory reads and the cell stage
// until the word is taken. Reset restores the register defaults (8 columns,
// match 1, mismatch -1, gap -1) and clears the previous row, row count and
// best values at once. Registers are written through cfg_we, cfg_index and
// cfg_data, by the user only while idle; the block does not enforce this.
`default_nettype none

`include "local_alignment_score_row_macros.svh"

module local_alignment_score_row (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  las_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output las_pkg::out_word_t                  out_data,
  input  logic                                cfg_we,
  input  logic [las_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [las_pkg::CFG_W-1:0]           cfg_data
);

  // Configuration registers.
  logic [las_pkg::ACT_W-1:0] active_columns;
  logic [3:0]                match_score;
  logic [4:0]                mismatch_score;
  logic [4:0]                gap_score;

  // Control state.
  las_pkg::state_t               state;
  las_pkg::state_t               state_next;
  logic                          issue_pending;
  logic [las_pkg::COL_IDX_W-1:0] issue_idx;
  logic [las_pkg::COL_IDX_W-1:0] last_idx;
  logic                          c_valid;
  logic [las_pkg::COL_IDX_W-1:0] c_idx;
  logic [las_pkg::SYMBOL_BITS-1:0] query_sym;

  // Memories and their registered read data.
  logic [las_pkg::SYMBOL_BITS-1:0] ref_mem  [las_pkg::MAX_COLUMNS];
  logic [las_pkg::SCORE_W-1:0]     prev_mem [las_pkg::MAX_COLUMNS];
  logic [las_pkg::MAX_COLUMNS-1:0] prev_valid;
  logic [las_pkg::SYMBOL_BITS-1:0] rd_ref;
  logic [las_pkg::SCORE_W-1:0]     rd_prev_raw;
  logic                            rd_valid;

  // Neighbors carried from the previous cell of the row.
  logic [las_pkg::SCORE_W-1:0] diag_score;
  logic [las_pkg::SCORE_W-1:0] left_nbr;

  // Running best values.
  logic [las_pkg::ROW_W-1:0]   row_count;
  logic [las_pkg::SCORE_W-1:0] top_score;
  logic [las_pkg::ROW_W-1:0]   top_row;
  logic [las_pkg::ACT_W-1:0]   top_col;

  logic                          in_fire;
  logic                          row_fire;
  logic                          load_fire;
  logic                          fresh;
  logic                          out_free;
  logic                          advance;
  logic                          issue;
  logic                          compute;
  logic                          row_done;
  logic [las_pkg::COL_IDX_W-1:0] last_idx_next;
  logic [las_pkg::ACT_W-1:0]     active_m1;
  logic [las_pkg::SCORE_W-1:0]   up_nbr;
  logic                          better;
  logic [las_pkg::ACT_W-1:0]     cur_col;
  las_pkg::cell_cfg_t            cell_cfg;
  las_pkg::cell_res_t            cell_out;

  assign in_ready  = (state == las_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign row_fire  = in_fire && (in_data.kind == las_pkg::KIND_ROW);
  assign load_fire = in_fire && (in_data.kind == las_pkg::KIND_LOAD);
  assign fresh     = row_fire && in_data.new_alignment;

  // The cell stage moves on when the output register is empty or draining,
  // and a new read is issued only when the cell stage can take its data.
  assign out_free = !out_valid || out_ready;
  assign advance  = !c_valid || out_free;
  assign issue    = (state == las_pkg::ST_ROW) && issue_pending && advance;
  assign compute  = c_valid && out_free;
  assign row_done = compute && (c_idx == last_idx);

  // Column count clamped to one through the store depth.
  assign active_m1 = active_columns - las_pkg::ACT_W'(1);
  always_comb begin
    priority if (active_columns == '0) begin
      last_idx_next = '0;
    end else if (active_columns > las_pkg::ACT_W'(las_pkg::MAX_COLUMNS)) begin
      last_idx_next = las_pkg::COL_IDX_W'(las_pkg::MAX_COLUMNS - 1);
    end else begin
      last_idx_next = active_m1[las_pkg::COL_IDX_W-1:0];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_columns <= las_pkg::ACTIVE_RESET;
      match_score    <= las_pkg::MATCH_RESET;
      mismatch_score <= las_pkg::MISMATCH_RESET;
      gap_score      <= las_pkg::GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        las_pkg::CFG_ACTIVE_COLUMNS: active_columns <= cfg_data[las_pkg::ACT_W-1:0];
        las_pkg::CFG_MATCH:          match_score    <= cfg_data[3:0];
        las_pkg::CFG_MISMATCH:       mismatch_score <= cfg_data[4:0];
        las_pkg::CFG_GAP:            gap_score      <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Row sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= las_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      las_pkg::ST_IDLE: begin
        if (row_fire) begin
          state_next = las_pkg::ST_ROW;
        end
      end
      las_pkg::ST_ROW: begin
        if (row_done) begin
          state_next = las_pkg::ST_IDLE;
        end
      end
      default: state_next = las_pkg::ST_IDLE;
    endcase
  end

  // Read issue counter and the cell stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_pending <= 1'b0;
      c_valid       <= 1'b0;
    end else begin
      if (row_fire) begin
        issue_pending <= 1'b1;
      end else if (issue && (issue_idx == last_idx)) begin
        issue_pending <= 1'b0;
      end
      if (advance) begin
        c_valid <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_fire) begin
      issue_idx <= '0;
      last_idx  <= last_idx_next;
      query_sym <= in_data.symbol[las_pkg::SYMBOL_BITS-1:0];
    end else if (issue) begin
      issue_idx <= issue_idx + las_pkg::COL_IDX_W'(1);
    end
    if (issue) begin
      c_idx <= issue_idx;
    end
  end

  // Reference store: written by loads, read a column a cycle unless stalled.
  always_ff @(posedge clk) begin
    if (load_fire && ({1'b0, in_data.load_column} < las_pkg::ACT_W'(las_pkg::MAX_COLUMNS))) begin
      ref_mem[in_data.load_column[las_pkg::COL_IDX_W-1:0]] <=
        in_data.symbol[las_pkg::SYMBOL_BITS-1:0];
    end
    if (issue) begin
      rd_ref <= ref_mem[issue_idx];
    end
  end

  // Previous-row score store. A column is read in the same cycle as the cell
  // stage writes the column to its left, so a row never reads an entry in
  // the cycle it is rewritten; the old left value survives in diag_score.
  always_ff @(posedge clk) begin
    if (compute) begin
      prev_mem[c_idx] <= cell_out.score;
    end
    if (issue) begin
      rd_prev_raw <= prev_mem[issue_idx];
      rd_valid    <= prev_valid[issue_idx];
    end
  end

  // Entries not written since reset or the last new alignment read as zero.
  always_ff @(posedge clk) begin
    if (rst || fresh) begin
      prev_valid <= '0;
    end else if (compute) begin
      prev_valid[c_idx] <= 1'b1;
    end
  end

  assign up_nbr = rd_valid ? rd_prev_raw : '0;

  assign cell_cfg.match_score    = match_score;
  assign cell_cfg.mismatch_score = mismatch_score;
  assign cell_cfg.gap_score      = gap_score;

  las_cell u_cell (
    .diag (diag_score),
    .up   (up_nbr),
    .left (left_nbr),
    .same (rd_ref == query_sym),
    .cfg  (cell_cfg),
    .res  (cell_out)
  );

  // Column 1 sees zero diagonal and left neighbors.
  always_ff @(posedge clk) begin
    if (row_fire) begin
      diag_score <= '0;
      left_nbr   <= '0;
    end else if (compute) begin
      diag_score <= up_nbr;
      left_nbr   <= cell_out.score;
    end
  end

  assign better  = cell_out.score > top_score;
  assign cur_col = las_pkg::ACT_W'(c_idx) + las_pkg::ACT_W'(1);

  // Row count and the running best.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      top_score <= '0;
      top_row   <= '0;
      top_col   <= '0;
    end else if (row_fire) begin
      if (fresh) begin
        row_count <= las_pkg::ROW_W'(1);
        top_score <= '0;
        top_row   <= '0;
        top_col   <= '0;
      end else if (row_count < las_pkg::ROW_W'(las_pkg::MAX_ROWS)) begin
        row_count <= row_count + las_pkg::ROW_W'(1);
      end
    end else if (compute && better) begin
      top_score <= cell_out.score;
      top_row   <= row_count;
      top_col   <= cur_col;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (compute) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (compute) begin
      out_data.column     <= cur_col;
      out_data.score      <= cell_out.score;
      out_data.direction  <= cell_out.dir;
      out_data.best_score <= better ? cell_out.score : top_score;
      out_data.best_row   <= better ? row_count : top_row;
      out_data.best_col   <= better ? cur_col : top_col;
      out_data.last       <= (c_idx == last_idx);
    end
  end

  // Nothing is left in the cell stage once the engine reports idle.
  `LAS_ASSERT_IMPLY(a_idle_stage_empty, in_ready, !c_valid && !issue_pending)
  // Finishing the final column returns the engine to idle.
  `LAS_ASSERT_NEXT(a_row_done_idle, row_done, in_ready)
  // The reported best can never be below the cell just reported.
  `LAS_ASSERT_IMPLY(a_best_covers, out_valid, out_data.best_score >= out_data.score)
  // A result with the last flag set carries the final active column.
  `LAS_ASSERT_NEXT(a_last_column, row_done,
                   out_valid && out_data.last
                   && (out_data.column == las_pkg::ACT_W'($past(last_idx)) + las_pkg::ACT_W'(1)))

endmodule

`default_nettype wire

/* sv/las_cell.sv */
`default_nettype none

// Scores one cell from its three neighbors and picks the traceback move.
module las_cell (
  input  logic [las_pkg::SCORE_W-1:0] diag,
  input  logic [las_pkg::SCORE_W-1:0] up,
  input  logic [las_pkg::SCORE_W-1:0] left,
  input  logic                        same,
  input  las_pkg::cell_cfg_t          cfg,
  output las_pkg::cell_res_t          res
);

  localparam int PadW = las_pkg::CALC_W - las_pkg::SCORE_W;

  logic signed [las_pkg::CALC_W-1:0] step;
  logic signed [las_pkg::CALC_W-1:0] gap_ext;
  logic signed [las_pkg::CALC_W-1:0] d;
  logic signed [las_pkg::CALC_W-1:0] u;
  logic signed [las_pkg::CALC_W-1:0] l;
  logic signed [las_pkg::CALC_W-1:0] s;
  logic signed [las_pkg::CALC_W-1:0] sat_lim;
  las_pkg::dir_t                     dir;

  always_comb begin
    step = same ? signed'({{(las_pkg::CALC_W - 4){1'b0}}, cfg.match_score})
                : signed'({{(las_pkg::CALC_W - 5){cfg.mismatch_score[4]}},
                           cfg.mismatch_score});
    gap_ext = signed'({{(las_pkg::CALC_W - 5){cfg.gap_score[4]}}, cfg.gap_score});
    d = signed'({{PadW{1'b0}}, diag}) + step;
    u = signed'({{PadW{1'b0}}, up}) + gap_ext;
    l = signed'({{PadW{1'b0}}, left}) + gap_ext;
    sat_lim = signed'(las_pkg::CALC_W'(las_pkg::SCORE_MAX));

    // Ties go to the diagonal first, then up, then left.
    priority if (d <= 0 && u <= 0 && l <= 0) begin
      s   = '0;
      dir = las_pkg::DIR_NONE;
    end else if (d >= u) begin
      if (d >= l) begin
        s   = d;
        dir = las_pkg::DIR_DIAG;
      end else begin
        s   = l;
        dir = las_pkg::DIR_LEFT;
      end
    end else if (u >= l) begin
      s   = u;
      dir = las_pkg::DIR_UP;
    end else begin
      s   = l;
      dir = las_pkg::DIR_LEFT;
    end

    res.dir   = dir;
    res.score = (s > sat_lim) ? las_pkg::SCORE_W'(las_pkg::SCORE_MAX)
                              : s[las_pkg::SCORE_W-1:0];
  end

endmodule

`default_nettype wire

/* tb/tb_local_alignment_score_row.sv */
`timescale 1ns / 1ps

// Self-checking bench for the Smith-Waterman score row engine.
//
// Every word that the engine accepts is also applied to a scoreboard
// model kept here: a copy of the reference column store, the previous row
// of scores, the row count and the running best cell. Each accepted row
// word produces one expected cell per active column, and these are queued
// in order. Every result word that leaves the engine is compared field by
// field against the oldest queued cell.
//
// The run goes through these parts:
//  - fill the whole column store, so that no row ever reads an entry that
//    was never written;
//  - a short directed table at the reset register values (symbol and
//    column extremes, loads outside the store, a new alignment flag on a
//    load, rows that match and rows that match nothing);
//  - several phases of random words, each under its own register setting,
//    with the extremes of every register among them and one phase with no
//    idling on either side.
//
// Both channels idle at random. The register port is only written once
// every expected cell has arrived and the engine has had time to settle.

module tb_local_alignment_score_row;
  import las_pkg::*;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          QUIET_CYCLES = 8;
  localparam int          END_CYCLES   = 40;
  localparam int          PHASES       = 7;
  localparam int          PHASE_WORDS  = 53;
  localparam logic [4:0]  PEN_MIN      = 5'b10000;  // -16
  localparam logic [4:0]  PEN_ONE      = 5'b11111;  // -1
  localparam logic [4:0]  PEN_ZERO     = 5'b00000;

  // A small alphabet makes matches frequent, so that the scores climb.
  localparam logic [7:0] ALPHABET [4] = '{8'h41, 8'h43, 8'h47, 8'h54};

  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t first_cell;
  } probe_t;

  // Directed words at the reset register values (8 columns, match 1,
  // mismatch -1, gap -1). Column c of the store holds 8'h40 + c before the
  // table starts. Where the first cell of a row is obvious it is typed in;
  // the rest of the row, and every other row, comes from the model.
  localparam probe_t PROBES [14] = '{
    '{'{KIND_LOAD, 8'h00, 6'd0,  1'b0}, 1'b0, '0},
    '{'{KIND_LOAD, 8'hFF, 6'd1,  1'b0}, 1'b0, '0},
    // Loads beyond the store are dropped; a wrap onto column 0 or 31 would
    // show up in later rows.
    '{'{KIND_LOAD, 8'h80, 6'd32, 1'b0}, 1'b0, '0},
    '{'{KIND_LOAD, 8'hFF, 6'd63, 1'b1}, 1'b0, '0},
    // A symbol that matches no column gives an all zero row.
    '{'{KIND_ROW,  8'h80, 6'd0,  1'b1}, 1'b1,
      '{7'd1, 10'd0, DIR_NONE, 10'd0, 13'd0, 7'd0, 1'b0}},
    // Row 2 matches column 1 and becomes the first best cell.
    '{'{KIND_ROW,  8'h00, 6'd0,  1'b0}, 1'b1,
      '{7'd1, 10'd1, DIR_DIAG, 10'd1, 13'd2, 7'd1, 1'b0}},
    '{'{KIND_ROW,  8'hFF, 6'd63, 1'b0}, 1'b0, '0},
    // A new alignment restarts the row count and the best cell.
    '{'{KIND_ROW,  8'h00, 6'd5,  1'b1}, 1'b1,
      '{7'd1, 10'd1, DIR_DIAG, 10'd1, 13'd1, 7'd1, 1'b0}},
    '{'{KIND_ROW,  8'h42, 6'd0,  1'b0}, 1'b0, '0},
    '{'{KIND_ROW,  8'h43, 6'd0,  1'b0}, 1'b0, '0},
    '{'{KIND_ROW,  8'h44, 6'd0,  1'b0}, 1'b0, '0},
    '{'{KIND_ROW,  8'hA5, 6'd0,  1'b0}, 1'b0, '0},
    '{'{KIND_LOAD, 8'hA5, 6'd7,  1'b0}, 1'b0, '0},
    '{'{KIND_ROW,  8'hA5, 6'd0,  1'b0}, 1'b0, '0}
  };

  logic                     clk;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  in_word_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_word_t                out_data;
  logic                     cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data  = '0;

  // Scoreboard copy of the engine's registers and state.
  logic [ACT_W-1:0]         active_cols  = ACTIVE_RESET;
  logic [3:0]               match_gain   = MATCH_RESET;
  logic signed [4:0]        mismatch_pen = MISMATCH_RESET;
  logic signed [4:0]        gap_pen      = GAP_RESET;
  logic [SYMBOL_BITS-1:0]   ref_symbols  [MAX_COLUMNS];
  logic [SCORE_W-1:0]       prior_scores [MAX_COLUMNS] = '{default: '0};
  logic [ROW_W-1:0]         rows_seen    = '0;
  logic [SCORE_W-1:0]       peak_score   = '0;
  logic [ROW_W-1:0]         peak_row     = '0;
  logic [6:0]               peak_col     = '0;

  out_word_t                pending_cells [$];
  int                       mismatches   = 0;
  int unsigned              cycles_run   = 0;
  bit                       idling_on    = 1'b1;

  local_alignment_score_row i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Scores one query row against the stored reference and returns the
  // expected cells in column order. The previous row, the row count and
  // the best cell are updated as the engine would update them.
  function automatic void score_query_row(input in_word_t w, output out_word_t cells [$]);
    logic [SCORE_W-1:0] row_scores [MAX_COLUMNS];
    int                 n, j, diag_in, up_in, left_in, d, u, l, s;
    dir_t               move;
    out_word_t          cell_word;
    cells = {};
    if (w.new_alignment) begin
      foreach (prior_scores[k]) prior_scores[k] = '0;
      rows_seen  = '0;
      peak_score = '0;
      peak_row   = '0;
      peak_col   = '0;
    end
    if (rows_seen < MAX_ROWS) rows_seen++;
    if (active_cols == 0) n = 1;
    else if (active_cols > MAX_COLUMNS) n = MAX_COLUMNS;
    else n = int'(active_cols);
    for (j = 0; j < n; j++) begin
      diag_in = (j == 0) ? 0 : int'(prior_scores[j-1]);
      up_in   = int'(prior_scores[j]);
      left_in = (j == 0) ? 0 : int'(row_scores[j-1]);
      d = diag_in + ((ref_symbols[j] == w.symbol) ? int'(match_gain) : int'(mismatch_pen));
      u = up_in + int'(gap_pen);
      l = left_in + int'(gap_pen);
      // Ties go to the diagonal first, then up, then left.
      if (d <= 0 && u <= 0 && l <= 0) begin
        s = 0;
        move = DIR_NONE;
      end else if (d >= u) begin
        s    = (d >= l) ? d : l;
        move = (d >= l) ? DIR_DIAG : DIR_LEFT;
      end else begin
        s    = (u >= l) ? u : l;
        move = (u >= l) ? DIR_UP : DIR_LEFT;
      end
      if (s > SCORE_MAX) s = SCORE_MAX;
      row_scores[j] = SCORE_W'(s);
      if (s > int'(peak_score)) begin
        peak_score = SCORE_W'(s);
        peak_row   = rows_seen;
        peak_col   = 7'(j + 1);
      end
      cell_word.column     = 7'(j + 1);
      cell_word.score      = row_scores[j];
      cell_word.direction  = move;
      cell_word.best_score = peak_score;
      cell_word.best_row   = peak_row;
      cell_word.best_col   = peak_col;
      cell_word.last       = (j + 1 == n);
      cells.push_back(cell_word);
    end
    for (j = 0; j < n; j++) prior_scores[j] = row_scores[j];
  endfunction

  // Offers one word on the input channel, holds it until it is taken, and
  // then applies it to the scoreboard. A typed first cell, where given,
  // stands in for the model's first cell of that row.
  task automatic send_word(input in_word_t w, input logic typed = 1'b0,
                           input out_word_t typed_cell = '0);
    out_word_t cells [$];
    while (idling_on && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (w.kind == KIND_LOAD) begin
      if (w.load_column < MAX_COLUMNS) ref_symbols[w.load_column[COL_IDX_W-1:0]] = w.symbol;
    end else begin
      score_query_row(w, cells);
      if (typed) cells[0] = typed_cell;
      foreach (cells[k]) pending_cells.push_back(cells[k]);
    end
  endtask

  // Stops sending and waits until every expected cell has come back, then
  // lets the engine settle so that a register write finds it idle.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers, one per cycle. Bits above a register's
  // width carry junk, which the engine must ignore.
  task automatic set_registers(input logic [ACT_W-1:0] cols, input logic [3:0] gain,
                               input logic [4:0] miss, input logic [4:0] gap);
    logic [6:0] junk;
    junk = 7'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ACTIVE_COLUMNS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_index <= CFG_MATCH;
    cfg_data  <= {junk[6:4], gain};
    @(posedge clk);
    cfg_index <= CFG_MISMATCH;
    cfg_data  <= {junk[1:0], miss};
    @(posedge clk);
    cfg_index <= CFG_GAP;
    cfg_data  <= {junk[3:2], gap};
    @(posedge clk);
    cfg_we       <= 1'b0;
    active_cols  = cols;
    match_gain   = gain;
    mismatch_pen = miss;
    gap_pen      = gap;
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // The receiver stalls at random while idling is on.
  always @(posedge clk) begin
    out_ready <= !idling_on || ($urandom_range(0, 99) >= 17);
  end

  // Every result word taken from the engine is held against the oldest
  // expected cell.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_cells.size() == 0) begin
        $error("result word for column %0d arrived with no cell expected", out_data.column);
        mismatches++;
      end else begin
        want = pending_cells.pop_front();
        check_field("column",     want.column,     out_data.column);
        check_field("score",      want.score,      out_data.score);
        check_field("direction",  want.direction,  out_data.direction);
        check_field("best_score", want.best_score, out_data.best_score);
        check_field("best_row",   want.best_row,   out_data.best_row);
        check_field("best_col",   want.best_col,   out_data.best_col);
        check_field("last",       want.last,       out_data.last);
      end
    end
  end

  // Watchdog for a hung handshake.
  always @(posedge clk) begin
    cycles_run++;
    if (cycles_run == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    in_word_t         w;
    int               c, phase, count, pick;
    logic [ACT_W-1:0] cols;
    logic [3:0]       gain;
    logic [4:0]       miss, gap;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole store first; rows never read an unwritten column.
    for (c = 0; c < MAX_COLUMNS; c++) begin
      w = '{KIND_LOAD, 8'(8'h40 + c), 6'(c), 1'b0};
      send_word(w);
    end

    foreach (PROBES[i]) send_word(PROBES[i].word, PROBES[i].typed, PROBES[i].first_cell);

    // Reload the store from the small alphabet so that random rows find
    // matches and build long diagonals.
    for (c = 0; c < MAX_COLUMNS; c++) begin
      w = '{KIND_LOAD, ALPHABET[$urandom_range(0, 3)], 6'(c), 1'b0};
      send_word(w);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      wait_for_drain();
      case (phase)
        0: set_registers(7'd1, 4'd15, PEN_MIN, PEN_MIN);
        1: set_registers(7'd127, 4'd15, PEN_ZERO, PEN_ZERO);
        2: set_registers(7'd32, 4'd2, PEN_ONE, PEN_ONE);
        3: set_registers(7'd0, 4'd3, PEN_MIN, PEN_ZERO);
        4: set_registers(7'd64, 4'd0, PEN_ZERO, PEN_MIN);
        default: begin
          pick = $urandom_range(0, 9);
          if (pick == 0) cols = '0;
          else if (pick == 1) cols = 7'($urandom_range(33, 127));
          else cols = 7'($urandom_range(1, 32));
          gain = 4'($urandom_range(0, 15));
          miss = 5'(0 - int'($urandom_range(0, 16)));
          gap  = 5'(0 - int'($urandom_range(0, 4)));
          set_registers(cols, gain, miss, gap);
        end
      endcase
      // One phase runs with both sides at full rate.
      idling_on = (phase != 2);
      for (count = 0; count < PHASE_WORDS; count++) begin
        w.kind          = ($urandom_range(0, 99) < 20) ? KIND_LOAD : KIND_ROW;
        w.symbol        = ($urandom_range(0, 99) < 85) ? ALPHABET[$urandom_range(0, 3)]
                                                       : 8'($urandom);
        w.load_column   = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(32, 63))
                                                      : 6'($urandom_range(0, 31));
        w.new_alignment = (count == 0) || ($urandom_range(0, 99) < 8);
        send_word(w);
      end
      idling_on = 1'b1;
    end

    wait_for_drain();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
